[rtl/cbsm_pkg.sv]
// cbsm_pkg: shared types and constants for the cartridge bank switch mapper.
// Used by cartridge_bank_switch_mapper; no dependencies.
package cbsm_pkg;

  localparam int ROM_BANK_BYTES    = 2048;
  localparam int RAM_BANK_BYTES    = 1024;
  localparam int RAM_BANKS_DEF     = 32;
  localparam int MAX_ROM_BANKS_DEF = 256;

  localparam int ROM_OFS_W  = $clog2(ROM_BANK_BYTES);
  localparam int RAM_OFS_W  = $clog2(RAM_BANK_BYTES);
  localparam int ADDR_W     = 13;
  localparam int DATA_W     = 8;
  localparam int BANK_W     = 9;
  localparam int ROM_ADDR_W = 19;
  localparam int RAM_ADDR_W = 15;
  localparam int ROM_IDX_W  = ROM_ADDR_W - ROM_OFS_W;
  localparam int RAM_IDX_W  = RAM_ADDR_W - RAM_OFS_W;

  localparam logic [ADDR_W-1:0] HOT_ROM_SEL  = 13'h003F;
  localparam logic [ADDR_W-1:0] HOT_RAM_SEL  = 13'h003E;
  localparam logic [ADDR_W-1:0] TIA_END      = 13'h0080;
  localparam logic [ADDR_W-1:0] WIN_BASE     = 13'h1000;
  localparam logic [ADDR_W-1:0] RAM_WR_BASE  = 13'h1400;
  localparam logic [ADDR_W-1:0] FIXED_BASE   = 13'h1800;

  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] CFG_ADDR_BANK_COUNT = 3'd0;
  localparam logic [BANK_W-1:0]     BANK_COUNT_RESET    = 9'd256;

  typedef enum logic [2:0] {
    ROUTE_NONE   = 3'd0,
    ROUTE_TIA    = 3'd1,
    ROUTE_ROM    = 3'd2,
    ROUTE_RAM_RD = 3'd3,
    ROUTE_RAM_WR = 3'd4
  } route_t;

  typedef struct packed {
    logic              mode;
    logic [ADDR_W-1:0] bus_address;
    logic [DATA_W-1:0] write_data;
  } in_item_t;

  typedef struct packed {
    route_t                route;
    logic [ROM_ADDR_W-1:0] rom_address;
    logic [RAM_ADDR_W-1:0] ram_address;
    logic [DATA_W-1:0]     data_out;
    logic [BANK_W-1:0]     selected_bank;
  } out_item_t;

endpackage

[rtl/cartridge_bank_switch_mapper.sv]
// cartridge_bank_switch_mapper: 3E-scheme bank switch decoder with a shared
// iterative remainder unit for bank selection. Depends on cbsm_pkg.
//
// Usage:
//   Input channel (in_valid/in_stall/in_data) carries one bus access per
//   transaction; result channel (out_valid/out_stall/out_data) returns one
//   decoded transaction for each access. The APB port holds rom_bank_count.
//   An ordinary access goes from acceptance to S_DONE, where its result is
//   registered; a write to a bank select hotspot first passes through S_DIV,
//   since its modulo is worked out by one restoring remainder step per data
//   bit (8 steps). in_stall is high while an access is in work, so a new
//   access is taken only once the last has left S_DONE. The output register
//   lets the next access be taken while a result waits; a finished access
//   holds in the sequencer until the output register is free, so a stalled
//   receiver holds back the input. Reset selects ROM bank 0, sets
//   rom_bank_count to 256 and empties the pipeline; there is no clearing pass.
module cartridge_bank_switch_mapper #(
  parameter int RAM_BANKS     = cbsm_pkg::RAM_BANKS_DEF,
  parameter int MAX_ROM_BANKS = cbsm_pkg::MAX_ROM_BANKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  cbsm_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output cbsm_pkg::out_item_t           out_data,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [cbsm_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);
  import cbsm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  in_item_t          item_r, item_nxt;
  logic [BANK_W-1:0] bank_count_r, bank_count_nxt;
  logic [BANK_W-1:0] cur_bank_r, cur_bank_nxt;
  logic [BANK_W-1:0] rem_r, rem_nxt;
  logic [BANK_W-1:0] divisor_r, divisor_nxt;
  logic [DATA_W-1:0] dvd_r, dvd_nxt;
  logic [2:0]        step_r, step_nxt;
  logic              sel_ram_r, sel_ram_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  logic [BANK_W-1:0] eff_count;
  logic [BANK_W-1:0] trial;
  logic [BANK_W-1:0] trial_sub;
  logic              cfg_wr;
  logic              hot_rom, hot_ram;
  logic              out_free;
  out_item_t         dec;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite &&
                  (cfg_paddr == CFG_ADDR_BANK_COUNT);
  assign cfg_prdata = (cfg_paddr == CFG_ADDR_BANK_COUNT) ?
                      {{(32-BANK_W){1'b0}}, bank_count_r} : 32'd0;

  always_comb begin
    eff_count = bank_count_r;
    if (bank_count_r == '0) begin
      eff_count = BANK_W'(1);
    end else if (bank_count_r > BANK_W'(MAX_ROM_BANKS)) begin
      eff_count = BANK_W'(MAX_ROM_BANKS);
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign hot_rom = in_data.mode && (in_data.bus_address == HOT_ROM_SEL);
  assign hot_ram = in_data.mode && (in_data.bus_address == HOT_RAM_SEL);

  // shared restoring remainder step
  assign trial     = {rem_r[BANK_W-2:0], dvd_r[DATA_W-1]};
  assign trial_sub = trial - divisor_r;

  // access decode against the bank selection after this access
  always_comb begin
    dec = '0;
    dec.selected_bank = cur_bank_r;
    if (item_r.bus_address < TIA_END) begin
      dec.route = ROUTE_TIA;
      if (item_r.mode) begin
        dec.data_out = item_r.write_data;
      end
    end else if (item_r.bus_address >= FIXED_BASE) begin
      if (!item_r.mode) begin
        dec.route       = ROUTE_ROM;
        dec.rom_address = {ROM_IDX_W'(eff_count - BANK_W'(1)),
                           item_r.bus_address[ROM_OFS_W-1:0]};
      end
    end else if (item_r.bus_address >= WIN_BASE) begin
      if (!cur_bank_r[BANK_W-1]) begin
        if (!item_r.mode) begin
          dec.route       = ROUTE_ROM;
          dec.rom_address = {ROM_IDX_W'(cur_bank_r[BANK_W-2:0]),
                             item_r.bus_address[ROM_OFS_W-1:0]};
        end
      end else if (!item_r.mode && (item_r.bus_address < RAM_WR_BASE)) begin
        dec.route       = ROUTE_RAM_RD;
        dec.ram_address = {cur_bank_r[RAM_IDX_W-1:0],
                           item_r.bus_address[RAM_OFS_W-1:0]};
      end else if (item_r.mode && (item_r.bus_address >= RAM_WR_BASE)) begin
        dec.route       = ROUTE_RAM_WR;
        dec.ram_address = {cur_bank_r[RAM_IDX_W-1:0],
                           item_r.bus_address[RAM_OFS_W-1:0]};
        dec.data_out    = item_r.write_data;
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    bank_count_nxt = bank_count_r;
    cur_bank_nxt   = cur_bank_r;
    rem_nxt        = rem_r;
    divisor_nxt    = divisor_r;
    dvd_nxt        = dvd_r;
    step_nxt       = step_r;
    sel_ram_nxt    = sel_ram_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_nxt        = out_r;

    if (cfg_wr) begin
      bank_count_nxt = cfg_pwdata[BANK_W-1:0];
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          if (hot_rom || hot_ram) begin
            rem_nxt     = '0;
            dvd_nxt     = in_data.write_data;
            step_nxt    = 3'd7;
            sel_ram_nxt = hot_ram;
            divisor_nxt = hot_ram ? BANK_W'(RAM_BANKS) : eff_count;
            state_nxt   = S_DIV;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DIV: begin
        dvd_nxt = {dvd_r[DATA_W-2:0], 1'b0};
        rem_nxt = (trial >= divisor_r) ? trial_sub : trial;
        step_nxt = step_r - 3'd1;
        if (step_r == 3'd0) begin
          cur_bank_nxt = sel_ram_r ? {1'b1, rem_nxt[BANK_W-2:0]} : rem_nxt;
          state_nxt    = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_nxt       = dec;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      bank_count_r <= BANK_COUNT_RESET;
      cur_bank_r   <= '0;
      out_valid_r  <= 1'b0;
      step_r       <= '0;
      sel_ram_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      bank_count_r <= bank_count_nxt;
      cur_bank_r   <= cur_bank_nxt;
      out_valid_r  <= out_valid_nxt;
      step_r       <= step_nxt;
      sel_ram_r    <= sel_ram_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    rem_r     <= rem_nxt;
    divisor_r <= divisor_nxt;
    dvd_r     <= dvd_nxt;
    out_r     <= out_nxt;
  end

endmodule

[sim/cartridge_bank_switch_mapper_test.sv]
// Self-checking testbench for cartridge_bank_switch_mapper: a directed access table,
// then random bus accesses under several ROM bank counts, checked against an in-bench decoder.
// Depends on cbsm_pkg and cartridge_bank_switch_mapper.
module cartridge_bank_switch_mapper_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cbsm_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int DRAIN_CYCLES    = 24;
  localparam int RAM_SELECT_BASE = 256;
  localparam int RAM_BANK_COUNT  = 32;
  localparam int MAX_BANKS       = 256;
  localparam int PHASE_ITEMS     = 128;
  localparam int HOLD_CYCLES     = 300;

  typedef struct {
    in_item_t  acc;
    bit        known;
    out_item_t res;
  } table_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0]           cfg_pwdata;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  logic [BANK_W-1:0] bank_sel;
  logic [BANK_W-1:0] rom_banks_reg;
  out_item_t         pending_decodes[$];
  table_row_t        access_table[$];
  int                mismatch_count;
  int                cycle_count;
  int                idle_pct;
  bit                hold_req;
  int                hold_left;
  int                pause_left;

  cartridge_bank_switch_mapper i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic int effective_banks();
    int n;
    n = int'(rom_banks_reg);
    if (n == 0) n = 1;
    if (n > MAX_BANKS) n = MAX_BANKS;
    return n;
  endfunction

  // Decodes one bus access and updates the bank selection.
  function automatic out_item_t decode_access(in_item_t acc);
    out_item_t r;
    int        ofs;
    int        ram_bank;
    r = '0;
    r.route = ROUTE_NONE;
    if (acc.bus_address < TIA_END) begin
      r.route = ROUTE_TIA;
      if (acc.mode) begin
        r.data_out = acc.write_data;
        if (acc.bus_address == HOT_ROM_SEL) begin
          bank_sel = BANK_W'(int'(acc.write_data) % effective_banks());
        end else if (acc.bus_address == HOT_RAM_SEL) begin
          bank_sel = BANK_W'(RAM_SELECT_BASE + int'(acc.write_data) % RAM_BANK_COUNT);
        end
      end
    end else if (acc.bus_address >= FIXED_BASE) begin
      if (!acc.mode) begin
        r.route = ROUTE_ROM;
        ofs = int'(acc.bus_address[ROM_OFS_W-1:0]);
        r.rom_address = ROM_ADDR_W'((effective_banks() - 1) * ROM_BANK_BYTES + ofs);
      end
    end else if (acc.bus_address >= WIN_BASE) begin
      if (int'(bank_sel) < RAM_SELECT_BASE) begin
        if (!acc.mode) begin
          r.route = ROUTE_ROM;
          ofs = int'(acc.bus_address[ROM_OFS_W-1:0]);
          r.rom_address = ROM_ADDR_W'(int'(bank_sel) * ROM_BANK_BYTES + ofs);
        end
      end else begin
        ram_bank = (int'(bank_sel) - RAM_SELECT_BASE) % RAM_BANK_COUNT;
        ofs = int'(acc.bus_address[RAM_OFS_W-1:0]);
        if (!acc.mode && acc.bus_address < RAM_WR_BASE) begin
          r.route = ROUTE_RAM_RD;
          r.ram_address = RAM_ADDR_W'(ram_bank * RAM_BANK_BYTES + ofs);
        end else if (acc.mode && acc.bus_address >= RAM_WR_BASE) begin
          r.route = ROUTE_RAM_WR;
          r.ram_address = RAM_ADDR_W'(ram_bank * RAM_BANK_BYTES + ofs);
          r.data_out = acc.write_data;
        end
      end
    end
    r.selected_bank = bank_sel;
    return r;
  endfunction

  function automatic void add_row(bit m, int addr, int data, bit known, route_t rt,
                                  int rom, int ram, int dout, int bank);
    table_row_t row;
    row.acc.mode = m;
    row.acc.bus_address = ADDR_W'(addr);
    row.acc.write_data = DATA_W'(data);
    row.known = known;
    row.res.route = rt;
    row.res.rom_address = ROM_ADDR_W'(rom);
    row.res.ram_address = RAM_ADDR_W'(ram);
    row.res.data_out = DATA_W'(dout);
    row.res.selected_bank = BANK_W'(bank);
    access_table.push_back(row);
  endfunction

  // Mostly well-formed traffic: bank selects followed by window accesses on the right port.
  function automatic in_item_t random_access();
    in_item_t acc;
    int       pick;
    pick = $urandom_range(0, 99);
    acc.write_data = DATA_W'($urandom_range(0, 255));
    acc.mode = 1'b0;
    if (pick < 12) begin
      acc.mode = 1'b1;
      acc.bus_address = HOT_ROM_SEL;
    end else if (pick < 22) begin
      acc.mode = 1'b1;
      acc.bus_address = HOT_RAM_SEL;
    end else if (pick < 30) begin
      acc.mode = 1'($urandom_range(0, 1));
      acc.bus_address = ADDR_W'($urandom_range(0, 'h7F));
    end else if (pick < 36) begin
      acc.mode = 1'($urandom_range(0, 1));
      acc.bus_address = ADDR_W'($urandom_range('h80, 'hFFF));
    end else if (pick < 80) begin
      acc.bus_address = ADDR_W'($urandom_range('h1000, 'h17FF));
      if (int'(bank_sel) >= RAM_SELECT_BASE && $urandom_range(0, 99) < 80) begin
        acc.mode = (acc.bus_address >= RAM_WR_BASE);
      end else begin
        acc.mode = ($urandom_range(0, 99) < 20);
      end
    end else begin
      acc.bus_address = ADDR_W'($urandom_range('h1800, 'h1FFF));
      acc.mode = ($urandom_range(0, 99) < 15);
    end
    return acc;
  endfunction

  task automatic offer_access(in_item_t acc, bit known, out_item_t typed);
    out_item_t predicted;
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= acc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = decode_access(acc);
    pending_decodes.push_back(known ? typed : predicted);
  endtask

  task automatic write_bank_count(logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_BANK_COUNT;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    rom_banks_reg = value[BANK_W-1:0];
  endtask

  task automatic wait_idle();
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic void check_result(out_item_t got);
    out_item_t want;
    if (pending_decodes.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("unexpected transaction: route %0d rom %h ram %h data %h bank %h",
                 got.route, got.rom_address, got.ram_address, got.data_out, got.selected_bank);
      return;
    end
    want = pending_decodes.pop_front();
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("mismatch exp: route %0d rom %h ram %h data %h bank %h",
                 want.route, want.rom_address, want.ram_address, want.data_out,
                 want.selected_bank);
        $display("         got: route %0d rom %h ram %h data %h bank %h",
                 got.route, got.rom_address, got.ram_address, got.data_out, got.selected_bank);
      end
    end
  endfunction

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("cartridge_bank_switch_mapper verification failed");
      $finish;
    end
  end

  // Result side: checks accepted transactions and drives random stalls and the long hold.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result(out_data);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (pause_left > 0) begin
        pause_left--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        pause_left = $urandom_range(0, 3);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    logic [31:0] bank_counts[$];
    out_item_t   blank;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    mismatch_count = 0;
    cycle_count = 0;
    idle_pct = 14;
    hold_req = 1'b0;
    hold_left = 0;
    pause_left = 0;
    bank_sel = '0;
    rom_banks_reg = BANK_COUNT_RESET;
    blank = '0;

    // reset state: 256 ROM banks, bank 0 selected
    add_row(0, 'h1000, 'h00, 1, ROUTE_ROM,    0,        0,      0,    0);
    add_row(0, 'h1FFF, 'hFF, 1, ROUTE_ROM,    'h7FFFF,  0,      0,    0);
    add_row(0, 'h0000, 'h00, 1, ROUTE_TIA,    0,        0,      0,    0);
    add_row(1, 'h007F, 'hFF, 1, ROUTE_TIA,    0,        0,      'hFF, 0);
    add_row(1, 'h003F, 'hFF, 1, ROUTE_TIA,    0,        0,      'hFF, 255);
    add_row(0, 'h17FF, 'h00, 1, ROUTE_ROM,    'h7FFFF,  0,      0,    255);
    add_row(1, 'h1000, 'h55, 1, ROUTE_NONE,   0,        0,      0,    255);
    add_row(1, 'h1FFF, 'hAA, 1, ROUTE_NONE,   0,        0,      0,    255);
    add_row(0, 'h0080, 'h00, 1, ROUTE_NONE,   0,        0,      0,    255);
    add_row(0, 'h0FFF, 'hFF, 1, ROUTE_NONE,   0,        0,      0,    255);
    add_row(1, 'h003E, 'hFF, 1, ROUTE_TIA,    0,        0,      'hFF, 287);
    add_row(0, 'h1000, 'h00, 1, ROUTE_RAM_RD, 0,        'h7C00, 0,    287);
    add_row(0, 'h13FF, 'h00, 1, ROUTE_RAM_RD, 0,        'h7FFF, 0,    287);
    add_row(1, 'h17FF, 'hA5, 1, ROUTE_RAM_WR, 0,        'h7FFF, 'hA5, 287);
    add_row(1, 'h1400, 'h00, 1, ROUTE_RAM_WR, 0,        'h7C00, 0,    287);
    add_row(0, 'h1400, 'h00, 1, ROUTE_NONE,   0,        0,      0,    287);
    add_row(1, 'h13FF, 'h3C, 1, ROUTE_NONE,   0,        0,      0,    287);
    add_row(0, 'h1800, 'h00, 1, ROUTE_ROM,    'h7F800,  0,      0,    287);
    add_row(1, 'h003E, 'h45, 0, ROUTE_NONE,   0,        0,      0,    0);
    add_row(0, 'h1234, 'h00, 0, ROUTE_NONE,   0,        0,      0,    0);
    add_row(1, 'h003F, 'h9C, 0, ROUTE_NONE,   0,        0,      0,    0);
    add_row(0, 'h1555, 'h00, 0, ROUTE_NONE,   0,        0,      0,    0);
    add_row(0, 'h003F, 'h01, 0, ROUTE_NONE,   0,        0,      0,    0);
    add_row(1, 'h003D, 'h5A, 0, ROUTE_NONE,   0,        0,      0,    0);
    add_row(1, 'h003F, 'h00, 1, ROUTE_TIA,    0,        0,      0,    0);

    // bank counts per phase: extremes, out-of-range values and ordinary ones
    bank_counts = '{32'd256, 32'd1, 32'd0, 32'd511, 32'd3, 32'hFFFF_FE05,
                    32'd37, 32'd300, 32'd2};
    bank_counts.push_back(32'($urandom_range(2, 255)));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (access_table[i])
      offer_access(access_table[i].acc, access_table[i].known, access_table[i].res);
    in_valid <= 1'b0;

    foreach (bank_counts[p]) begin
      wait_idle();
      write_bank_count(bank_counts[p]);
      idle_pct = (p == 2) ? 0 : 14;
      if (p == 5) hold_req = 1'b1;
      repeat (PHASE_ITEMS - 13) offer_access(random_access(), 1'b0, blank);
      in_valid <= 1'b0;
    end

    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("cartridge_bank_switch_mapper verification clean");
    end else begin
      $display("cartridge_bank_switch_mapper verification failed");
    end
    $finish;
  end

endmodule
